// File: sv/bhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, codes and defaults for the binary heap priority queue core.
// ----------------------------------------------------------------------------
package bhpq_pkg;

   localparam int DEF_CAPACITY  = 1024;
   localparam int DEF_KEY_WIDTH = 32;
   localparam int OUT_KEY_W     = 32;
   localparam int OUT_COUNT_W   = 11;
   localparam int STATUS_W      = 2;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic MODE_MAX_FIRST = 1'b0;
   localparam logic MODE_MIN_FIRST = 1'b1;

   typedef struct packed {
      logic                 cmd;
      logic [OUT_KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [OUT_KEY_W-1:0]   popped_key;
      logic [STATUS_W-1:0]    status;
      logic [OUT_KEY_W-1:0]   top_key;
      logic                   top_valid;
      logic [OUT_COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_POP_LD,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_LAST,
      RD_PARENT,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_CUR,
      WR_UP,
      WR_DN
   } wr_sel_type;

   typedef struct packed {
      logic       accept;
      rd_sel_type rd_sel;
      logic       cur_load;
      logic       lval_load;
      wr_sel_type wr_sel;
      logic       rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_full;
      logic is_empty;
      logic count_one;
      logic pos_zero;
      logic up_swap;
      logic left_in;
      logic dn_move;
   } ctrl_status_type;

endpackage

// File: sv/binary_heap_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core
// Binary heap priority queue with push and pop of unsigned keys.
// ----------------------------------------------------------------------------
// One item is worked at a time. A push climbs the new key level by level,
// reading the parent and comparing; a pop moves the last entry to the root
// and sinks it level by level, reading the left child and then the right.
// Errors and a pop that leaves the store empty go straight to the result.
// The pace is set by the single read port of the store RAM, one read per
// cycle with registered data. A finished result sits in an output register,
// so the next transfer is taken while it waits; a result that is still held
// when the next one finishes holds the core in its last cycle. The store
// needs no clearing after reset. The order bit on csr_wr_data selects
// largest-first (0) or smallest-first (1).
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_core #(
   parameter int CAPACITY  = bhpq_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = bhpq_pkg::DEF_KEY_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bhpq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bhpq_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   bhpq_pkg::ctrl_cmd_type    cmd;
   bhpq_pkg::ctrl_status_type stat;

   bhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_payload.cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bhpq_dp #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: sv/bhpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bhpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Sequencer for push sift-up and pop sift-down, and result channel valid.
// ----------------------------------------------------------------------------
module bhpq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_cmd,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  bhpq_pkg::ctrl_status_type stat,
   output bhpq_pkg::ctrl_cmd_type    cmd
);

   bhpq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   assign req_stall = (state_ff != bhpq_pkg::ST_IDLE);
   assign accept    = req_valid && (state_ff == bhpq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bhpq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bhpq_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_cmd == bhpq_pkg::CMD_PUSH) begin
                  state_in = stat.is_full ? bhpq_pkg::ST_DONE : bhpq_pkg::ST_UP_RD;
               end else if (stat.is_empty || stat.count_one) begin
                  state_in = bhpq_pkg::ST_DONE;
               end else begin
                  state_in = bhpq_pkg::ST_POP_RD;
               end
            end
         end
         bhpq_pkg::ST_POP_RD: state_in = bhpq_pkg::ST_POP_LD;
         bhpq_pkg::ST_POP_LD: state_in = bhpq_pkg::ST_DN_RDL;
         bhpq_pkg::ST_UP_RD: begin
            state_in = stat.pos_zero ? bhpq_pkg::ST_DONE : bhpq_pkg::ST_UP_CMP;
         end
         bhpq_pkg::ST_UP_CMP: begin
            state_in = stat.up_swap ? bhpq_pkg::ST_UP_RD : bhpq_pkg::ST_DONE;
         end
         bhpq_pkg::ST_DN_RDL: begin
            state_in = stat.left_in ? bhpq_pkg::ST_DN_RDR : bhpq_pkg::ST_DONE;
         end
         bhpq_pkg::ST_DN_RDR: state_in = bhpq_pkg::ST_DN_CMP;
         bhpq_pkg::ST_DN_CMP: begin
            state_in = stat.dn_move ? bhpq_pkg::ST_DN_RDL : bhpq_pkg::ST_DONE;
         end
         bhpq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = bhpq_pkg::ST_IDLE;
            end
         end
         default: state_in = bhpq_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.rd_sel = bhpq_pkg::RD_NONE;
      cmd.wr_sel = bhpq_pkg::WR_NONE;
      unique case (state_ff)
         bhpq_pkg::ST_IDLE:   cmd.accept = accept;
         bhpq_pkg::ST_POP_RD: cmd.rd_sel = bhpq_pkg::RD_LAST;
         bhpq_pkg::ST_POP_LD: cmd.cur_load = 1'b1;
         bhpq_pkg::ST_UP_RD: begin
            if (stat.pos_zero) begin
               cmd.wr_sel = bhpq_pkg::WR_CUR;
            end else begin
               cmd.rd_sel = bhpq_pkg::RD_PARENT;
            end
         end
         bhpq_pkg::ST_UP_CMP: begin
            cmd.wr_sel = stat.up_swap ? bhpq_pkg::WR_UP : bhpq_pkg::WR_CUR;
         end
         bhpq_pkg::ST_DN_RDL: begin
            if (stat.left_in) begin
               cmd.rd_sel = bhpq_pkg::RD_LEFT;
            end else begin
               cmd.wr_sel = bhpq_pkg::WR_CUR;
            end
         end
         bhpq_pkg::ST_DN_RDR: begin
            cmd.rd_sel    = bhpq_pkg::RD_RIGHT;
            cmd.lval_load = 1'b1;
         end
         bhpq_pkg::ST_DN_CMP: begin
            cmd.wr_sel = stat.dn_move ? bhpq_pkg::WR_DN : bhpq_pkg::WR_CUR;
         end
         bhpq_pkg::ST_DONE: cmd.rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

endmodule

// File: sv/bhpq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_dp
// Heap datapath: store RAM, sift position, held key, counts and result register.
// ----------------------------------------------------------------------------
module bhpq_dp #(
   parameter int CAPACITY  = bhpq_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = bhpq_pkg::DEF_KEY_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bhpq_pkg::req_type         req_payload,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  bhpq_pkg::ctrl_cmd_type    cmd,
   output bhpq_pkg::ctrl_status_type stat,
   output bhpq_pkg::rsp_type         rsp_payload
);

   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int CHW = AW + 2;

   logic                        mode_ff, mode_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic [KEY_WIDTH-1:0]        cur_ff, cur_in;
   logic [KEY_WIDTH-1:0]        lval_ff, lval_in;
   logic [KEY_WIDTH-1:0]        root_ff, root_in;
   logic [KEY_WIDTH-1:0]        popped_ff, popped_in;
   logic [bhpq_pkg::STATUS_W-1:0] status_ff, status_in;
   bhpq_pkg::rsp_type           rsp_ff, rsp_in;

   logic [KEY_WIDTH-1:0] req_key;
   logic [KEY_WIDTH-1:0] rd_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_data_addr;
   logic [KEY_WIDTH-1:0] wr_data;

   logic [AW-1:0]  parent_idx;
   logic [CHW-1:0] left_w, right_w, count_w;
   logic           right_in;
   logic           pick_left, pick_right;
   logic [KEY_WIDTH-1:0] best_val, child_val;
   logic [AW-1:0]  child_idx;

   logic [bhpq_pkg::OUT_KEY_W-1:0]   popped_out, root_out;
   logic [bhpq_pkg::OUT_COUNT_W-1:0] count_out;

   function automatic logic serves_before(input logic mode, input logic [KEY_WIDTH-1:0] a,
                                          input logic [KEY_WIDTH-1:0] b);
      if (mode == bhpq_pkg::MODE_MAX_FIRST) begin
         return a > b;
      end
      return a < b;
   endfunction

   generate
      if (KEY_WIDTH >= bhpq_pkg::OUT_KEY_W) begin : g_key_wide
         assign req_key    = KEY_WIDTH'(req_payload.key);
         assign popped_out = popped_ff[bhpq_pkg::OUT_KEY_W-1:0];
         assign root_out   = root_ff[bhpq_pkg::OUT_KEY_W-1:0];
      end else begin : g_key_narrow
         assign req_key    = req_payload.key[KEY_WIDTH-1:0];
         assign popped_out = bhpq_pkg::OUT_KEY_W'(popped_ff);
         assign root_out   = bhpq_pkg::OUT_KEY_W'(root_ff);
      end
      if (CW >= bhpq_pkg::OUT_COUNT_W) begin : g_cnt_wide
         assign count_out = count_in[bhpq_pkg::OUT_COUNT_W-1:0];
      end else begin : g_cnt_narrow
         assign count_out = bhpq_pkg::OUT_COUNT_W'(count_in);
      end
   endgenerate

   bhpq_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_data_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign parent_idx = (pos_ff - AW'(1)) >> 1;
   assign left_w     = (CHW'(pos_ff) << 1) + CHW'(1);
   assign right_w    = (CHW'(pos_ff) << 1) + CHW'(2);
   assign count_w    = CHW'(count_ff);
   assign right_in   = right_w < count_w;

   assign pick_left  = serves_before(mode_ff, lval_ff, cur_ff);
   assign best_val   = pick_left ? lval_ff : cur_ff;
   assign pick_right = right_in && serves_before(mode_ff, rd_data, best_val);
   assign child_val  = pick_right ? rd_data : lval_ff;
   assign child_idx  = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];

   assign stat.is_full   = count_ff == CW'(CAPACITY);
   assign stat.is_empty  = count_ff == '0;
   assign stat.count_one = count_ff == CW'(1);
   assign stat.pos_zero  = pos_ff == '0;
   assign stat.up_swap   = serves_before(mode_ff, cur_ff, rd_data);
   assign stat.left_in   = left_w < count_w;
   assign stat.dn_move   = pick_left || pick_right;

   always_comb begin
      rd_en   = cmd.rd_sel != bhpq_pkg::RD_NONE;
      rd_addr = '0;
      unique case (cmd.rd_sel)
         bhpq_pkg::RD_NONE:   rd_addr = '0;
         bhpq_pkg::RD_LAST:   rd_addr = count_ff[AW-1:0];
         bhpq_pkg::RD_PARENT: rd_addr = parent_idx;
         bhpq_pkg::RD_LEFT:   rd_addr = left_w[AW-1:0];
         bhpq_pkg::RD_RIGHT:  rd_addr = right_w[AW-1:0];
         default:             rd_addr = '0;
      endcase
   end

   always_comb begin
      wr_en        = cmd.wr_sel != bhpq_pkg::WR_NONE;
      wr_data_addr = pos_ff;
      wr_data      = cur_ff;
      pos_in       = pos_ff;
      unique case (cmd.wr_sel)
         bhpq_pkg::WR_NONE: ;
         bhpq_pkg::WR_CUR:  wr_data = cur_ff;
         bhpq_pkg::WR_UP: begin
            wr_data = rd_data;
            pos_in  = parent_idx;
         end
         bhpq_pkg::WR_DN: begin
            wr_data = child_val;
            pos_in  = child_idx;
         end
         default: ;
      endcase
      if (cmd.cur_load) begin
         pos_in = '0;
      end
      if (cmd.accept && req_payload.cmd == bhpq_pkg::CMD_PUSH) begin
         pos_in = count_ff[AW-1:0];
      end
   end

   always_comb begin
      mode_in   = csr_wr_en ? csr_wr_data : mode_ff;
      count_in  = count_ff;
      cur_in    = cmd.cur_load ? rd_data : cur_ff;
      lval_in   = cmd.lval_load ? rd_data : lval_ff;
      root_in   = (wr_en && wr_data_addr == '0) ? wr_data : root_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      if (cmd.accept) begin
         popped_in = '0;
         status_in = bhpq_pkg::STATUS_OK;
         if (req_payload.cmd == bhpq_pkg::CMD_PUSH) begin
            if (stat.is_full) begin
               status_in = bhpq_pkg::STATUS_FULL;
            end else begin
               cur_in   = req_key;
               count_in = count_ff + CW'(1);
            end
         end else if (stat.is_empty) begin
            status_in = bhpq_pkg::STATUS_EMPTY;
         end else begin
            popped_in = root_ff;
            count_in  = count_ff - CW'(1);
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.popped_key  = popped_out;
         rsp_in.status      = status_ff;
         rsp_in.top_valid   = count_ff != '0;
         rsp_in.top_key     = (count_ff != '0) ? root_out : '0;
         rsp_in.entry_count = count_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= bhpq_pkg::MODE_MAX_FIRST;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      cur_ff    <= cur_in;
      lval_ff   <= lval_in;
      root_ff   <= root_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

// File: tb/tb_binary_heap_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_heap_priority_queue_core
// Self-checking bench for the binary heap priority queue core.
// ----------------------------------------------------------------------------
// A behavioral heap tracks every accepted push and pop and predicts the
// popped key, status, root and entry count of each result. Directed tests
// cover the empty store, extreme keys, ties and both serving orders; a fill
// test drives the store to capacity and past it; a pressure test holds the
// result channel off until the core stalls its input; random phases mix
// pushes and pops under changing orders, including order changes while
// entries are held. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_binary_heap_priority_queue_core;

   localparam int CAPACITY    = bhpq_pkg::DEF_CAPACITY;
   localparam int KEY_W       = bhpq_pkg::OUT_KEY_W;
   localparam int HOLD_CYCLES = 300;
   localparam int FULL_POPS   = 16;
   localparam int CYCLE_LIMIT = 3_000_000;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   bhpq_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   bhpq_pkg::rsp_type rsp_payload;
   logic              csr_wr_en   = 1'b0;
   logic              csr_wr_data = 1'b0;

   logic [KEY_W-1:0] heap_keys [0:CAPACITY-1];
   int               heap_size;
   logic             serve_order;

   bhpq_pkg::rsp_type pending_rsp[$];
   bhpq_pkg::rsp_type want_rsp;
   int                mismatch_count = 0;
   int                result_index   = 0;
   int                cycle_count    = 0;
   bit                send_idle_on   = 1'b1;
   bit                recv_idle_on   = 1'b1;
   bit                hold_req       = 1'b0;

   binary_heap_priority_queue_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model
   function automatic bit key_precedes(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
      if (serve_order == bhpq_pkg::MODE_MAX_FIRST) return a > b;
      return a < b;
   endfunction

   function automatic void heap_swap(int i, int j);
      logic [KEY_W-1:0] t;
      t            = heap_keys[i];
      heap_keys[i] = heap_keys[j];
      heap_keys[j] = t;
   endfunction

   function automatic bhpq_pkg::rsp_type heap_apply(bhpq_pkg::req_type item);
      bhpq_pkg::rsp_type r;
      int                pos;
      int                parent;
      int                best;
      int                left;
      int                right;
      bit                done;
      r = '0;
      r.status = bhpq_pkg::STATUS_OK;
      if (item.cmd == bhpq_pkg::CMD_PUSH) begin
         if (heap_size >= CAPACITY) begin
            r.status = bhpq_pkg::STATUS_FULL;
         end else begin
            heap_keys[heap_size] = item.key;
            heap_size++;
            pos  = heap_size - 1;
            done = 1'b0;
            while (pos > 0 && !done) begin
               parent = (pos - 1) / 2;
               if (key_precedes(heap_keys[pos], heap_keys[parent])) begin
                  heap_swap(pos, parent);
                  pos = parent;
               end else begin
                  done = 1'b1;
               end
            end
         end
      end else begin
         if (heap_size == 0) begin
            r.status = bhpq_pkg::STATUS_EMPTY;
         end else begin
            r.popped_key = heap_keys[0];
            heap_size--;
            heap_keys[0] = heap_keys[heap_size];
            pos  = 0;
            done = 1'b0;
            while (pos < heap_size && !done) begin
               best  = pos;
               left  = 2 * pos + 1;
               right = 2 * pos + 2;
               if (left < heap_size && key_precedes(heap_keys[left], heap_keys[best]))
                  best = left;
               if (right < heap_size && key_precedes(heap_keys[right], heap_keys[best]))
                  best = right;
               if (best == pos) begin
                  done = 1'b1;
               end else begin
                  heap_swap(pos, best);
                  pos = best;
               end
            end
         end
      end
      r.top_valid   = (heap_size > 0);
      r.top_key     = (heap_size > 0) ? heap_keys[0] : '0;
      r.entry_count = heap_size[bhpq_pkg::OUT_COUNT_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------- helpers
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom;
      if (r < 85) return $urandom_range(0, 15);
      if (r < 92) return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 3));
      return $urandom_range(0, 3);
   endfunction

   task automatic report_mismatch(string what, logic [KEY_W-1:0] got,
                                  logic [KEY_W-1:0] want);
      $display("mismatch on result %0d, %s: got %0h, expected %0h",
               result_index, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_request(logic cmd, logic [KEY_W-1:0] key);
      bhpq_pkg::req_type item;
      int                gap;
      item.cmd = cmd;
      item.key = key;
      gap = send_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(heap_apply(item));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() > 0);
   endtask

   task automatic write_order(logic mode);
      drain_results();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      serve_order = mode;
   endtask

   // ------------------------------------------------------ result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_payload.popped_key, '0);
         end else begin
            want_rsp = pending_rsp.pop_front();
            if (rsp_payload.popped_key !== want_rsp.popped_key)
               report_mismatch("popped_key", rsp_payload.popped_key, want_rsp.popped_key);
            if (rsp_payload.status !== want_rsp.status)
               report_mismatch("status", KEY_W'(rsp_payload.status),
                               KEY_W'(want_rsp.status));
            if (rsp_payload.top_key !== want_rsp.top_key)
               report_mismatch("top_key", rsp_payload.top_key, want_rsp.top_key);
            if (rsp_payload.top_valid !== want_rsp.top_valid)
               report_mismatch("top_valid", KEY_W'(rsp_payload.top_valid),
                               KEY_W'(want_rsp.top_valid));
            if (rsp_payload.entry_count !== want_rsp.entry_count)
               report_mismatch("entry_count", KEY_W'(rsp_payload.entry_count),
                               KEY_W'(want_rsp.entry_count));
         end
         result_index++;
      end
   end

   // ------------------------------------------------------- result stalls
   initial begin : rsp_stall_gen
      int run;
      int hold_left;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            hold_left = HOLD_CYCLES;
            while (hold_left > 0) begin
               @(posedge clock);
               hold_left--;
            end
            rsp_stall <= 1'b0;
            hold_req = 1'b0;
         end else begin
            run = recv_idle_on ? pick_gap() : 0;
            if (run > 0) begin
               rsp_stall <= 1'b1;
               repeat (run) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------ watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // --------------------------------------------------------------- tests
   task automatic test_max_order_basics();
      write_order(bhpq_pkg::MODE_MAX_FIRST);
      send_request(bhpq_pkg::CMD_POP, 32'h1234_5678);
      send_request(bhpq_pkg::CMD_PUSH, 32'h0000_0000);
      send_request(bhpq_pkg::CMD_PUSH, 32'hFFFF_FFFF);
      send_request(bhpq_pkg::CMD_PUSH, 32'h0000_0005);
      send_request(bhpq_pkg::CMD_PUSH, 32'h0000_0005);
      send_request(bhpq_pkg::CMD_PUSH, 32'h0000_0007);
      repeat (5) send_request(bhpq_pkg::CMD_POP, 32'hFFFF_FFFF);
      send_request(bhpq_pkg::CMD_POP, 32'h0000_0000);
      drain_results();
   endtask

   task automatic test_min_order_basics();
      write_order(bhpq_pkg::MODE_MIN_FIRST);
      send_request(bhpq_pkg::CMD_PUSH, 32'hFFFF_FFFF);
      send_request(bhpq_pkg::CMD_PUSH, 32'h0000_0000);
      send_request(bhpq_pkg::CMD_PUSH, 32'h0000_0009);
      send_request(bhpq_pkg::CMD_PUSH, 32'h0000_0009);
      repeat (4) send_request(bhpq_pkg::CMD_POP, 32'h0000_0000);
      send_request(bhpq_pkg::CMD_POP, 32'hAAAA_5555);
      drain_results();
   endtask

   task automatic test_full_store();
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      write_order(bhpq_pkg::MODE_MAX_FIRST);
      while (heap_size < CAPACITY) send_request(bhpq_pkg::CMD_PUSH, pick_key());
      send_request(bhpq_pkg::CMD_PUSH, 32'hFFFF_FFFF);
      write_order(bhpq_pkg::MODE_MIN_FIRST);
      send_request(bhpq_pkg::CMD_PUSH, 32'h0000_0000);
      send_request(bhpq_pkg::CMD_POP, '0);
      send_request(bhpq_pkg::CMD_PUSH, 32'h0000_0001);
      send_request(bhpq_pkg::CMD_PUSH, 32'h0000_0002);
      repeat (FULL_POPS) send_request(bhpq_pkg::CMD_POP, '0);
      drain_results();
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      int i;
      send_idle_on = 1'b0;
      hold_req = 1'b1;
      for (i = 0; i < 16; i++)
         send_request(($urandom_range(0, 3) == 0) ? bhpq_pkg::CMD_POP : bhpq_pkg::CMD_PUSH,
                      pick_key());
      drain_results();
      wait (hold_req == 1'b0);
      send_idle_on = 1'b1;
   endtask

   task automatic run_traffic(int count, int push_pct);
      int i;
      for (i = 0; i < count; i++)
         send_request(($urandom_range(0, 99) < push_pct) ? bhpq_pkg::CMD_PUSH
                                                         : bhpq_pkg::CMD_POP,
                      pick_key());
   endtask

   task automatic test_random_traffic();
      write_order(bhpq_pkg::MODE_MAX_FIRST);
      run_traffic(20, 65);
      write_order(bhpq_pkg::MODE_MIN_FIRST);
      run_traffic(15, 50);
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      run_traffic(15, 30);
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      write_order(bhpq_pkg::MODE_MAX_FIRST);
      run_traffic(15, 55);
      recv_idle_on = 1'b0;
      run_traffic(15, 35);
      recv_idle_on = 1'b1;
      write_order(bhpq_pkg::MODE_MIN_FIRST);
      send_idle_on = 1'b0;
      run_traffic(10, 60);
      send_idle_on = 1'b1;
      drain_results();
   endtask

   initial begin
      heap_size   = 0;
      serve_order = bhpq_pkg::MODE_MAX_FIRST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_max_order_basics();
      test_min_order_basics();
      test_backpressure();
      test_random_traffic();
      test_full_store();

      drain_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
